// ===== src/tci_pkg.sv =====
package tci_pkg;

	// Fixed grid bound: cells and robot at this index or beyond pass through
	localparam logic [16:0] GRID_SIDE   = 17'd4096;

	// Trust scale, Q1.16
	localparam logic [16:0] TRUST_FULL  = 17'd65536;
	localparam logic [16:0] TRUST_HIGH  = 17'd65471;
	localparam logic [7:0]  PEAK_SCALE  = 8'd200;
	localparam logic [15:0] ONE_CELL    = 16'd256;
	localparam logic [7:0]  COST_LETHAL = 8'd254;

	// Register indexes on the configuration port
	localparam logic [2:0] CFG_ENABLED   = 3'd0;
	localparam logic [2:0] CFG_ROBOT_COL = 3'd1;
	localparam logic [2:0] CFG_ROBOT_ROW = 3'd2;
	localparam logic [2:0] CFG_BASE_RAD  = 3'd3;
	localparam logic [2:0] CFG_TRUST     = 3'd4;

	// Pipeline shape
	localparam int SQ_STAGES = 8;  // two root bits per stage, 16 bits
	localparam int DV_STAGES = 4;  // two quotient bits per stage, 8 bits
	localparam int LATENCY   = 5 + SQ_STAGES + DV_STAGES;

	typedef struct packed {
		logic [11:0] cell_col;
		logic [11:0] cell_row;
		logic [7:0]  old_cost;
	} tci_in_t;

	typedef struct packed {
		logic [7:0] new_cost;
		logic       raised;
	} tci_out_t;

endpackage

// ===== src/tapered_cost_inflation_core.sv =====
// An accepted item passes the s1, s2, s3, square-root, radius and divide stages.
// Throughput: one item per cycle; busy stays low, every stage moves each cycle.
// The distance square root runs two bits per stage over 8 stages, the taper
// divide two bits per stage over 4 stages.
// Reset (arst_n low, asynchronous) drops all items in flight and restores the
// register defaults. The receiver cannot stall; results are shown for one cycle.
module tapered_cost_inflation_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tci_pkg::tci_in_t item,
	output logic             done,
	output tci_pkg::tci_out_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [16:0]      cfg_data
);

	localparam int SQN = tci_pkg::SQ_STAGES;
	localparam int DVN = tci_pkg::DV_STAGES;
	localparam int LAT = tci_pkg::LATENCY;

	// Square root pipeline record
	typedef struct packed {
		logic [7:0]  cost;
		logic        pass;
		logic [7:0]  peak;
		logic [15:0] r;
		logic [31:0] rad;
		logic [17:0] rem;
		logic [15:0] root;
	} sq_t;

	// Divide pipeline record
	typedef struct packed {
		logic [7:0]  cost;
		logic        pass;
		logic [15:0] r;
		logic [23:0] num;
		logic [7:0]  q;
	} dv_t;

	// One root bit: bring down two radicand bits, try (root*4 + 1)
	function automatic sq_t sq_bit(sq_t s);
		sq_t         o;
		logic [19:0] rn;
		logic [19:0] trial;
		o     = s;
		rn    = {s.rem, s.rad[31:30]};
		trial = {2'b00, s.root, 2'b01};
		o.rad = {s.rad[29:0], 2'b00};
		if (rn >= trial) begin
			o.rem  = 18'(rn - trial);
			o.root = {s.root[14:0], 1'b1};
		end else begin
			o.rem  = 18'(rn);
			o.root = {s.root[14:0], 1'b0};
		end
		return o;
	endfunction

	// One quotient bit of num / r at weight b
	function automatic dv_t dv_bit(dv_t s, int b);
		dv_t         o;
		logic [23:0] sh;
		o  = s;
		sh = 24'(s.r) << b;
		if (s.num >= sh) begin
			o.num  = s.num - sh;
			o.q[b] = 1'b1;
		end
		return o;
	endfunction

	// Configuration registers
	logic        enabled_q;
	logic [11:0] robot_col_q;
	logic [11:0] robot_row_q;
	logic [15:0] base_radius_q;
	logic [16:0] trust_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			robot_col_q   <= 12'd0;
			robot_row_q   <= 12'd0;
			base_radius_q <= 16'd384;
			trust_q       <= 17'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tci_pkg::CFG_ENABLED:   enabled_q     <= cfg_data[0];
				tci_pkg::CFG_ROBOT_COL: robot_col_q   <= cfg_data[11:0];
				tci_pkg::CFG_ROBOT_ROW: robot_row_q   <= cfg_data[11:0];
				tci_pkg::CFG_BASE_RAD:  base_radius_q <= cfg_data[15:0];
				tci_pkg::CFG_TRUST:     trust_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: trust terms, pass-through checks, offsets to the robot
	logic        accept;
	logic [16:0] trust_c;
	logic [16:0] distrust;
	logic [32:0] rad_prod;
	logic [24:0] peak_prod;
	logic [15:0] r_c;
	logic        byp_c;
	logic [11:0] dx_c;
	logic [11:0] dy_c;

	assign accept = start && !busy;

	always_comb begin
		trust_c   = (trust_q > tci_pkg::TRUST_FULL) ? tci_pkg::TRUST_FULL : trust_q;
		distrust  = tci_pkg::TRUST_FULL - trust_c;
		rad_prod  = 33'(base_radius_q) * 33'(distrust);
		peak_prod = 25'(distrust) * 25'(tci_pkg::PEAK_SCALE);
		r_c       = (rad_prod[31:16] < tci_pkg::ONE_CELL) ? tci_pkg::ONE_CELL
		                                                  : rad_prod[31:16];
		byp_c     = !enabled_q || (trust_c >= tci_pkg::TRUST_HIGH)
		          || (item.old_cost >= tci_pkg::COST_LETHAL)
		          || ({5'b0, item.cell_col} >= tci_pkg::GRID_SIDE)
		          || ({5'b0, item.cell_row} >= tci_pkg::GRID_SIDE)
		          || ({5'b0, robot_col_q} >= tci_pkg::GRID_SIDE)
		          || ({5'b0, robot_row_q} >= tci_pkg::GRID_SIDE)
		          || (rad_prod == 33'd0);
		dx_c      = (item.cell_col >= robot_col_q) ? item.cell_col - robot_col_q
		                                           : robot_col_q - item.cell_col;
		dy_c      = (item.cell_row >= robot_row_q) ? item.cell_row - robot_row_q
		                                           : robot_row_q - item.cell_row;
	end

	// Valid bits, one per stage
	logic [LAT-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	// Payload registers
	logic [7:0]  cost_s1, cost_s2, peak_s1, peak_s2;
	logic        byp_s1, byp_s2;
	logic [15:0] r_s1, r_s2;
	logic [11:0] dx_s1, dy_s1;
	logic [23:0] dx2_s2, dy2_s2;
	sq_t         sq_s [SQN+1];
	dv_t         dv_s [DVN+1];
	tci_pkg::tci_out_t out_s;

	// Square-root stage input and radius-test terms
	logic [24:0] sum_c;
	logic [15:0] d_c;
	logic        far_c;
	logic [15:0] diff_c;

	always_comb begin
		sum_c  = 25'(dx2_s2) + 25'(dy2_s2);
		d_c    = sq_s[SQN].root;
		far_c  = sq_s[SQN].pass || (d_c > sq_s[SQN].r);
		diff_c = sq_s[SQN].r - d_c;
	end

	always_ff @(posedge clk) begin
		// s1: register item and trust terms
		cost_s1 <= item.old_cost;
		byp_s1  <= byp_c;
		peak_s1 <= peak_prod[23:16];
		r_s1    <= r_c;
		dx_s1   <= dx_c;
		dy_s1   <= dy_c;
		// s2: squares
		cost_s2 <= cost_s1;
		byp_s2  <= byp_s1;
		peak_s2 <= peak_s1;
		r_s2    <= r_s1;
		dx2_s2  <= 24'(dx_s1) * 24'(dx_s1);
		dy2_s2  <= 24'(dy_s1) * 24'(dy_s1);
		// s3: squared distance; 65536 or more is beyond any radius
		sq_s[0].cost <= cost_s2;
		sq_s[0].pass <= byp_s2 || (sum_c[24:16] != 9'd0);
		sq_s[0].peak <= peak_s2;
		sq_s[0].r    <= r_s2;
		sq_s[0].rad  <= {sum_c[15:0], 16'h0000};
		sq_s[0].rem  <= '0;
		sq_s[0].root <= '0;
		// square root, two bits per stage
		for (int k = 1; k <= SQN; k++) begin
			sq_s[k] <= sq_bit(sq_bit(sq_s[k-1]));
		end
		// radius test and taper numerator
		dv_s[0].cost <= sq_s[SQN].cost;
		dv_s[0].pass <= far_c;
		dv_s[0].r    <= sq_s[SQN].r;
		dv_s[0].num  <= 24'(sq_s[SQN].peak) * 24'(diff_c);
		dv_s[0].q    <= '0;
		// divide by radius, two quotient bits per stage
		for (int k = 0; k < DVN; k++) begin
			dv_s[k+1] <= dv_bit(dv_bit(dv_s[k], 7 - 2 * k), 6 - 2 * k);
		end
		// output: keep the larger cost, or the old cost for a pass-through item
		if (!dv_s[DVN].pass && (dv_s[DVN].q > dv_s[DVN].cost)) begin
			out_s.new_cost <= dv_s[DVN].q;
			out_s.raised   <= 1'b1;
		end else begin
			out_s.new_cost <= dv_s[DVN].cost;
			out_s.raised   <= 1'b0;
		end
	end

	assign done   = vld_s[LAT-1];
	assign result = out_s;

endmodule

// ===== src/tci_checker.sv =====
module tci_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input tci_pkg::tci_in_t  item,
	input logic              done,
	input tci_pkg::tci_out_t result
);

	localparam int LAT = tci_pkg::LATENCY;
	localparam int CW  = $clog2(LAT + 1);

	// Edges seen since reset, saturating at the latency
	logic [CW-1:0] cnt_q;
	logic          warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != CW'(LAT)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign warm = (cnt_q == CW'(LAT));

	// Each accepted item gives exactly one result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match an accepted item");

	// A raised cost never exceeds the peak
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.raised) |-> (result.new_cost <= tci_pkg::PEAK_SCALE))
		else $error("raised cost above peak");

	// Cost never drops, and raised flags exactly a change
	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done) |->
		((result.new_cost >= $past(item.old_cost, LAT)) &&
		 (result.raised == (result.new_cost != $past(item.old_cost, LAT)))))
		else $error("cost lowered or raised flag wrong");

	// Unknown and lethal cells pass through
	a_lethal: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && ($past(item.old_cost, LAT) >= tci_pkg::COST_LETHAL))
		|-> !result.raised)
		else $error("unknown or lethal cell modified");

endmodule

bind tapered_cost_inflation_core tci_checker u_tci_checker (.*);
